>>> src/vna_pkg.sv
// Package for the vertex normal accumulator.
// Holds the command kinds, the queued command type and the state machine encodings.
// Has no dependencies.
package vna_pkg;

	localparam int IDX_W = 10;
	localparam int POS_W = 16;
	localparam int NRM_W = 16;
	localparam int SUM_W = 48;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int IN_DATA_W = 80;
	localparam int OUT_DATA_W = 64;
	localparam int UNIT_ONE = 16384;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_TRI = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	typedef enum logic [1:0] {
		K_WRITE,
		K_TRI,
		K_READ,
		K_READ_ZERO
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [IDX_W-1:0] ia;
		logic [IDX_W-1:0] ib;
		logic [IDX_W-1:0] ic;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
	} cmd_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic zero;
	} norm_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRPOS,
		ST_RDA,
		ST_RDB,
		ST_RDC,
		ST_CAPC,
		ST_DIFF,
		ST_MUL,
		ST_CROSS,
		ST_SRD,
		ST_SADD,
		ST_NRD,
		ST_NSTART,
		ST_NWAIT,
		ST_OUT
	} back_state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SHIFT,
		N_SQ,
		N_AA,
		N_HH,
		N_CMP,
		N_DONE
	} norm_state_t;

endpackage

>>> src/vna_front.sv
// Front end of the vertex normal accumulator: accepts input transactions,
// classifies them and queues the commands for the back end. Uses vna_pkg.
module vna_front #(
	parameter int VERTEX_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vertex_index, pos_x, pos_y, pos_z, corner_b, corner_c, zero pad
	input  logic [vna_pkg::IN_DATA_W-1:0] s_tdata,
	// operation
	input  logic [1:0] s_tuser,
	output vna_pkg::cmd_t cmd,
	output logic cmd_valid,
	input  logic cmd_ready
);

	vna_pkg::cmd_t in_cmd;
	logic keep;
	logic ok_a, ok_b, ok_c;
	vna_pkg::cmd_t queue_q [vna_pkg::QDEPTH];
	logic [vna_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [vna_pkg::QPTR_W:0] count_q;
	logic push, pop;

	always_comb begin
		in_cmd.ia = s_tdata[9:0];
		in_cmd.px = s_tdata[25:10];
		in_cmd.py = s_tdata[41:26];
		in_cmd.pz = s_tdata[57:42];
		in_cmd.ib = s_tdata[67:58];
		in_cmd.ic = s_tdata[77:68];
		ok_a = 32'(in_cmd.ia) < 32'(VERTEX_DEPTH);
		ok_b = 32'(in_cmd.ib) < 32'(VERTEX_DEPTH);
		ok_c = 32'(in_cmd.ic) < 32'(VERTEX_DEPTH);
		unique case (s_tuser)
			vna_pkg::OP_WRITE: begin
				in_cmd.kind = vna_pkg::K_WRITE;
				keep = ok_a;
			end
			vna_pkg::OP_TRI: begin
				in_cmd.kind = vna_pkg::K_TRI;
				keep = ok_a && ok_b && ok_c;
			end
			vna_pkg::OP_READ: begin
				in_cmd.kind = ok_a ? vna_pkg::K_READ : vna_pkg::K_READ_ZERO;
				keep = 1'b1;
			end
			default: begin
				in_cmd.kind = vna_pkg::K_READ_ZERO;
				keep = 1'b0;
			end
		endcase
	end

	assign s_tready = count_q != (vna_pkg::QPTR_W+1)'(vna_pkg::QDEPTH);
	assign push = s_tvalid && s_tready && keep;
	assign cmd_valid = count_q != '0;
	assign pop = cmd_valid && cmd_ready;
	assign cmd = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/vna_norm.sv
// Iterative normalizer: scales a 48-bit sum vector to a unit vector in Q1.14.
// Shifts into range, sums squares, then finds each output bit by bit. Uses vna_pkg.
module vna_norm (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [3*vna_pkg::SUM_W-1:0] sums,
	output logic done,
	output vna_pkg::norm_res_t res
);

	localparam int SW = vna_pkg::SUM_W;

	vna_pkg::norm_state_t state_q, state_d;
	logic [SW-1:0] a_q [3];
	logic [2:0] neg_q;
	logic [SW-1:0] m_q;
	logic [31:0] t_q;
	logic [29:0] aa_q, hh_q;
	logic [14:0] c_q, q_q, qn;
	logic skip_q;
	logic [3:0] bit_q;
	logic [1:0] comp_q;
	logic [1:0] cnt_q;
	logic [SW-1:0] mag [3];
	logic [SW-1:0] mx;
	logic [15:0] cand;
	logic [14:0] hval;
	logic [61:0] lhs;
	logic [vna_pkg::NRM_W-1:0] res_q [3];
	logic zero_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = sums[i*SW+SW-1] ? SW'(-sums[i*SW +: SW]) : sums[i*SW +: SW];
		end
		mx = mag[0];
		if (mag[1] > mx) begin
			mx = mag[1];
		end
		if (mag[2] > mx) begin
			mx = mag[2];
		end
		cand = {1'b0, q_q} | (16'd1 << bit_q);
		hval = 15'((cand << 1) - 16'd1);
		lhs = 62'(hh_q) * 62'(t_q);
		qn = (!skip_q && lhs <= {2'b00, aa_q, 30'd0}) ? c_q : q_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vna_pkg::N_IDLE: begin
				if (start) begin
					state_d = (mx == '0) ? vna_pkg::N_DONE : vna_pkg::N_SHIFT;
				end
			end
			vna_pkg::N_SHIFT: begin
				if (m_q[SW-1:15] == '0) begin
					state_d = vna_pkg::N_SQ;
				end
			end
			vna_pkg::N_SQ: begin
				if (cnt_q == 2'd2) begin
					state_d = vna_pkg::N_AA;
				end
			end
			vna_pkg::N_AA: state_d = vna_pkg::N_HH;
			vna_pkg::N_HH: state_d = vna_pkg::N_CMP;
			vna_pkg::N_CMP: begin
				if (bit_q != '0) begin
					state_d = vna_pkg::N_HH;
				end else if (comp_q == 2'd2) begin
					state_d = vna_pkg::N_DONE;
				end else begin
					state_d = vna_pkg::N_AA;
				end
			end
			vna_pkg::N_DONE: state_d = vna_pkg::N_IDLE;
			default: state_d = vna_pkg::N_IDLE;
		endcase
	end

	always_comb begin
		done = state_q == vna_pkg::N_DONE;
		res.nx = res_q[0];
		res.ny = res_q[1];
		res.nz = res_q[2];
		res.zero = zero_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vna_pkg::N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vna_pkg::N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= mag[i];
						neg_q[i] <= sums[i*SW+SW-1];
						res_q[i] <= '0;
					end
					m_q <= mx;
					zero_q <= mx == '0;
					t_q <= '0;
					cnt_q <= '0;
					comp_q <= '0;
				end
			end
			vna_pkg::N_SHIFT: begin
				if (m_q[SW-1:15] != '0) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] >> 1;
					end
				end
			end
			vna_pkg::N_SQ: begin
				t_q <= t_q + 32'(30'(a_q[cnt_q][14:0]) * 30'(a_q[cnt_q][14:0]));
				cnt_q <= cnt_q + 1'b1;
			end
			vna_pkg::N_AA: begin
				aa_q <= 30'(a_q[comp_q][14:0]) * 30'(a_q[comp_q][14:0]);
				q_q <= '0;
				bit_q <= 4'd15;
			end
			vna_pkg::N_HH: begin
				skip_q <= cand > 16'(vna_pkg::UNIT_ONE);
				c_q <= cand[14:0];
				hh_q <= 30'(hval) * 30'(hval);
			end
			vna_pkg::N_CMP: begin
				q_q <= qn;
				if (bit_q != '0) begin
					bit_q <= bit_q - 1'b1;
				end else begin
					res_q[comp_q] <= neg_q[comp_q] ? -16'(qn) : 16'(qn);
					comp_q <= comp_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> src/vna_back.sv
// Back end of the vertex normal accumulator: a sequencer over the position and
// sum memories with the cross product datapath and an output register.
// Uses vna_pkg and vna_norm.
module vna_back #(
	parameter int VERTEX_DEPTH = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  vna_pkg::cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_ready,
	output logic m_tvalid,
	input  logic m_tready,
	// out_index, normal_x, normal_y, normal_z, zero pad
	output logic [vna_pkg::OUT_DATA_W-1:0] m_tdata,
	// zero_normal
	output logic [0:0] m_tuser
);

	localparam int AW = $clog2(VERTEX_DEPTH);
	localparam int CB = COORD_BITS;
	localparam int DW = CB + 1;
	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;
	localparam int SW = vna_pkg::SUM_W;
	localparam int XW = ((CW > SW) ? CW : SW) + 1;

	logic [3*CB-1:0] pos_mem [VERTEX_DEPTH];
	logic [3*SW-1:0] sum_mem [VERTEX_DEPTH];

	vna_pkg::back_state_t state_q, state_d;
	vna_pkg::cmd_t cmd_q;
	logic [AW-1:0] pos_raddr, sum_raddr, sum_waddr;
	logic [3*CB-1:0] pos_rdata_q, pa_q, pb_q, pc_q;
	logic [3*SW-1:0] sum_rdata_q, sum_wdata;
	logic pos_we, sum_we;
	logic signed [DW-1:0] u_q [3];
	logic signed [DW-1:0] v_q [3];
	logic signed [PW-1:0] prod_q [6];
	logic signed [CW-1:0] n_q [3];
	logic signed [DW-1:0] mul_a, mul_b;
	logic [2:0] cnt_q;
	logic [1:0] corner_q;
	logic [vna_pkg::IDX_W-1:0] corner_idx;
	logic norm_start, norm_done;
	vna_pkg::norm_res_t norm_res;
	logic out_load;
	logic m_tvalid_q;
	logic [vna_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic m_zero_q;
	logic signed [XW-1:0] sat_sum;
	logic signed [XW-1:0] sat_max, sat_min;

	vna_norm u_norm (
		.clk   (clk),
		.arst_n(arst_n),
		.start (norm_start),
		.sums  (sum_rdata_q),
		.done  (norm_done),
		.res   (norm_res)
	);

	always_comb begin
		unique case (corner_q)
			2'd0: corner_idx = cmd_q.ia;
			2'd1: corner_idx = cmd_q.ib;
			default: corner_idx = cmd_q.ic;
		endcase
		unique case (cnt_q)
			3'd0: begin mul_a = u_q[1]; mul_b = v_q[2]; end
			3'd1: begin mul_a = u_q[2]; mul_b = v_q[1]; end
			3'd2: begin mul_a = u_q[2]; mul_b = v_q[0]; end
			3'd3: begin mul_a = u_q[0]; mul_b = v_q[2]; end
			3'd4: begin mul_a = u_q[0]; mul_b = v_q[1]; end
			default: begin mul_a = u_q[1]; mul_b = v_q[0]; end
		endcase
		sat_max = XW'({1'b0, {(SW-1){1'b1}}});
		sat_min = -sat_max - XW'(1);
		sum_wdata = '0;
		for (int i = 0; i < 3; i++) begin
			sat_sum = XW'($signed(sum_rdata_q[i*SW +: SW])) + XW'(n_q[i]);
			if (sat_sum > sat_max) begin
				sat_sum = sat_max;
			end else if (sat_sum < sat_min) begin
				sat_sum = sat_min;
			end
			sum_wdata[i*SW +: SW] = SW'(sat_sum);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vna_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.kind)
						vna_pkg::K_WRITE: state_d = vna_pkg::ST_WRPOS;
						vna_pkg::K_TRI: state_d = vna_pkg::ST_RDA;
						vna_pkg::K_READ: state_d = vna_pkg::ST_NRD;
						default: state_d = vna_pkg::ST_OUT;
					endcase
				end
			end
			vna_pkg::ST_WRPOS: state_d = vna_pkg::ST_IDLE;
			vna_pkg::ST_RDA: state_d = vna_pkg::ST_RDB;
			vna_pkg::ST_RDB: state_d = vna_pkg::ST_RDC;
			vna_pkg::ST_RDC: state_d = vna_pkg::ST_CAPC;
			vna_pkg::ST_CAPC: state_d = vna_pkg::ST_DIFF;
			vna_pkg::ST_DIFF: state_d = vna_pkg::ST_MUL;
			vna_pkg::ST_MUL: begin
				if (cnt_q == 3'd5) begin
					state_d = vna_pkg::ST_CROSS;
				end
			end
			vna_pkg::ST_CROSS: state_d = vna_pkg::ST_SRD;
			vna_pkg::ST_SRD: state_d = vna_pkg::ST_SADD;
			vna_pkg::ST_SADD: begin
				state_d = (corner_q == 2'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_SRD;
			end
			vna_pkg::ST_NRD: state_d = vna_pkg::ST_NSTART;
			vna_pkg::ST_NSTART: state_d = vna_pkg::ST_NWAIT;
			vna_pkg::ST_NWAIT: begin
				if (norm_done) begin
					state_d = vna_pkg::ST_OUT;
				end
			end
			vna_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = vna_pkg::ST_IDLE;
				end
			end
			default: state_d = vna_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = state_q == vna_pkg::ST_IDLE;
		pos_we = state_q == vna_pkg::ST_WRPOS;
		sum_we = (state_q == vna_pkg::ST_WRPOS) || (state_q == vna_pkg::ST_SADD);
		norm_start = state_q == vna_pkg::ST_NSTART;
		out_load = (state_q == vna_pkg::ST_OUT) && (!m_tvalid_q || m_tready);
		pos_raddr = AW'(cmd_q.ia);
		if (state_q == vna_pkg::ST_RDB) begin
			pos_raddr = AW'(cmd_q.ib);
		end else if (state_q == vna_pkg::ST_RDC) begin
			pos_raddr = AW'(cmd_q.ic);
		end
		sum_raddr = (state_q == vna_pkg::ST_SRD) ? AW'(corner_idx) : AW'(cmd_q.ia);
		sum_waddr = (state_q == vna_pkg::ST_SADD) ? AW'(corner_idx) : AW'(cmd_q.ia);
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[AW'(cmd_q.ia)] <= {CB'(cmd_q.pz), CB'(cmd_q.py), CB'(cmd_q.px)};
		end
		pos_rdata_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_waddr] <= (state_q == vna_pkg::ST_SADD) ? sum_wdata : '0;
		end
		sum_rdata_q <= sum_mem[sum_raddr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			vna_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
				cnt_q <= '0;
				corner_q <= '0;
			end
			vna_pkg::ST_RDB: pa_q <= pos_rdata_q;
			vna_pkg::ST_RDC: pb_q <= pos_rdata_q;
			vna_pkg::ST_CAPC: pc_q <= pos_rdata_q;
			vna_pkg::ST_DIFF: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i] <= DW'($signed(pb_q[i*CB +: CB])) - DW'($signed(pa_q[i*CB +: CB]));
					v_q[i] <= DW'($signed(pc_q[i*CB +: CB])) - DW'($signed(pa_q[i*CB +: CB]));
				end
			end
			vna_pkg::ST_MUL: begin
				prod_q[cnt_q] <= PW'(mul_a) * PW'(mul_b);
				cnt_q <= cnt_q + 1'b1;
			end
			vna_pkg::ST_CROSS: begin
				n_q[0] <= CW'(prod_q[0]) - CW'(prod_q[1]);
				n_q[1] <= CW'(prod_q[2]) - CW'(prod_q[3]);
				n_q[2] <= CW'(prod_q[4]) - CW'(prod_q[5]);
			end
			vna_pkg::ST_SADD: corner_q <= corner_q + 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd_q.kind == vna_pkg::K_READ) begin
				m_tdata_q <= {6'd0, norm_res.nz, norm_res.ny, norm_res.nx, cmd_q.ia};
				m_zero_q <= norm_res.zero;
			end else begin
				m_tdata_q <= {54'd0, cmd_q.ia};
				m_zero_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vna_pkg::ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_zero_q;

endmodule

>>> src/vertex_normal_accumulator.sv
// Top level of the vertex normal accumulator.
// Connects the front end queue to the back end sequencer. Uses vna_pkg, vna_front, vna_back.
//
// The block stores vertex positions and per-vertex sums of area-weighted face normals.
// A triangle transaction does three position reads, six products through one multiplier
// and three read-modify-writes of the sum memory. A read runs the normalizer: a range
// shift of up to 33 bits, one bit at a time, then the sum of the squares, then a
// bit-by-bit scaling search for each component. A read of a zero sum skips these steps,
// and a read of a vertex beyond the depth bypasses the normalizer. A four-entry queue
// lets input transactions be taken while the back end works, and an output register
// holds a finished result.
module vertex_normal_accumulator #(
	parameter int VERTEX_DEPTH = 1024,
	parameter int COORD_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vertex_index, pos_x, pos_y, pos_z, corner_b, corner_c, zero pad
	input  logic [vna_pkg::IN_DATA_W-1:0] s_tdata,
	// operation
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// out_index, normal_x, normal_y, normal_z, zero pad
	output logic [vna_pkg::OUT_DATA_W-1:0] m_tdata,
	// zero_normal
	output logic [0:0] m_tuser
);

	vna_pkg::cmd_t cmd;
	logic cmd_valid, cmd_ready;

	vna_front #(
		.VERTEX_DEPTH(VERTEX_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready)
	);

	vna_back #(
		.VERTEX_DEPTH(VERTEX_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
